>>> rtl/pba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pba_pkg: shared definitions of the page bitmap allocator
// Sizes, result codes, command codes and the queue entry that carries one
// classified request from the front end to the bitmap engine.
// ----------------------------------------------------------------------------
package pba_pkg;

	// geometry
	localparam int MAX_PAGES   = 4096;
	localparam int PAGE_BYTES  = 4096;
	localparam int WORD_BITS   = 64;
	localparam int NUM_WORDS   = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
	localparam int WORD_IDX_W  = $clog2(NUM_WORDS);
	localparam int BIT_IDX_W   = $clog2(WORD_BITS);
	localparam int PAGE_W      = $clog2(MAX_PAGES);
	localparam int RUN_W       = BIT_IDX_W + 1;

	// field widths
	localparam int CNT_W       = 13;
	localparam int ADDR_W      = 32;
	localparam int OUT_ADDR_W  = 24;
	localparam int STATUS_W    = 3;
	localparam int START_W     = ADDR_W - PAGE_SHIFT;

	// request queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE       = 3'd0,
		ST_NO_RUN     = 3'd1,
		ST_ZERO       = 3'd2,
		ST_MISALIGNED = 3'd3,
		ST_RANGE      = 3'd4
	} pba_status_t;

	// work for the engine
	typedef enum logic [1:0] {
		OP_RESULT = 2'd0,	// answer only, no bitmap access
		OP_ALLOC  = 2'd1,
		OP_FREE   = 2'd2
	} pba_op_t;

	typedef struct packed {
		pba_op_t             op;
		pba_status_t         status;
		logic [PAGE_W-1:0]   start;
		logic [CNT_W-1:0]    count;
	} pba_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} pba_q_stat_t;

endpackage
`default_nettype wire

>>> rtl/page_bitmap_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Answer-only requests (zero count, count above a word, rejected free) skip the
// bitmap and go straight to the result register. Allocate reads one bitmap word
// per cycle until a run is found or the words run out. Free reads and rewrites
// each word spanned. One request is worked at a time; a 2-deep queue keeps
// accepting meanwhile. Reset marks all pages used at once through per-word
// valid bits (no clearing pass) and sets total_pages to 4096.
// ----------------------------------------------------------------------------
// page_bitmap_allocator_core: bitmap page frame allocator
// Front end classifies request beats, a short queue decouples it from the
// bitmap engine, which searches, marks and clears runs of pages.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_core (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [pba_pkg::CNT_W-1:0]        total_pages,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire                              command,
	input  wire  [pba_pkg::CNT_W-1:0]        page_count,
	input  wire  [pba_pkg::ADDR_W-1:0]       address,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [pba_pkg::OUT_ADDR_W-1:0]   alloc_address,
	output logic [pba_pkg::STATUS_W-1:0]     status
);
	import pba_pkg::*;

	pba_q_stat_t      q_stat;
	pba_entry_t       q_entry;
	pba_entry_t       q_head;
	logic             q_push;
	logic             q_pop;
	logic [CNT_W-1:0] eff_pages;

	pba_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.total_pages (total_pages),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.page_count  (page_count),
		.address     (address),
		.q_stat      (q_stat),
		.q_push      (q_push),
		.q_entry     (q_entry),
		.eff_pages   (eff_pages)
	);

	pba_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.head       (q_head),
		.stat       (q_stat)
	);

	pba_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.eff_pages     (eff_pages),
		.q_head        (q_head),
		.q_stat        (q_stat),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.alloc_address (alloc_address),
		.status        (status)
	);

`ifndef ASSERT_OFF
	// the engine only takes work that is there
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	// the front end never writes a full queue
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("queue pushed while full");

	// a nonzero address only comes with a successful allocate
	a_addr_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (alloc_address == '0 || status == STATUS_W'(ST_DONE)))
		else $error("address returned with a failure status");
`endif

endmodule
`default_nettype wire

>>> rtl/pba_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pba_front: request front end
// Holds the total_pages register, accepts request beats and classifies them:
// rejected and trivial requests become answer-only entries, the rest become
// allocate or free jobs for the bitmap engine.
// ----------------------------------------------------------------------------
module pba_front (
	input  wire                          clk,
	input  wire                          arst_n,
	// configuration
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [pba_pkg::CNT_W-1:0]    total_pages,
	// request channel
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire                          command,
	input  wire  [pba_pkg::CNT_W-1:0]    page_count,
	input  wire  [pba_pkg::ADDR_W-1:0]   address,
	// queue side
	input  pba_pkg::pba_q_stat_t         q_stat,
	output logic                         q_push,
	output pba_pkg::pba_entry_t          q_entry,
	output logic [pba_pkg::CNT_W-1:0]    eff_pages
);
	import pba_pkg::*;

	logic [CNT_W-1:0]   total_pages_q;
	logic [START_W-1:0] start_page;
	logic [START_W:0]   end_sum;
	logic               misaligned;
	logic               out_of_range;

	// config register, taken at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_pages_q <= CNT_W'(MAX_PAGES);
		end else if (cfg_valid && cfg_ready) begin
			total_pages_q <= total_pages;
		end
	end

	// clamp to the tracked size
	assign eff_pages = (total_pages_q > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
	                                                        : total_pages_q;

	// handshake
	assign in_stall = q_stat.full;
	assign q_push   = in_valid && !in_stall;

	// free checks
	assign start_page   = address[ADDR_W-1:PAGE_SHIFT];
	assign end_sum      = {1'b0, start_page} + (START_W+1)'(page_count);
	assign misaligned   = address[PAGE_SHIFT-1:0] != '0;
	assign out_of_range = end_sum > (START_W+1)'(eff_pages);

	// classify the beat
	always_comb begin
		q_entry.op     = OP_RESULT;
		q_entry.status = ST_DONE;
		q_entry.start  = start_page[PAGE_W-1:0];
		q_entry.count  = page_count;
		if (command == CMD_ALLOC) begin
			if (page_count == '0) begin
				q_entry.status = ST_ZERO;
			end else if (page_count > CNT_W'(WORD_BITS)) begin
				// a run never spans two words
				q_entry.status = ST_NO_RUN;
			end else begin
				q_entry.op = OP_ALLOC;
			end
		end else begin
			if (misaligned) begin
				q_entry.status = ST_MISALIGNED;
			end else if (out_of_range) begin
				q_entry.status = ST_RANGE;
			end else if (page_count != '0) begin
				q_entry.op = OP_FREE;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/pba_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pba_queue: request queue
// Short FIFO of classified requests between the front end and the engine.
// ----------------------------------------------------------------------------
module pba_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  pba_pkg::pba_entry_t   push_entry,
	input  wire                   pop,
	output pba_pkg::pba_entry_t   head,
	output pba_pkg::pba_q_stat_t  stat
);
	import pba_pkg::*;

	pba_entry_t        slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign stat.full  = fill_q == QCNT_W'(QUEUE_DEPTH);
	assign stat.empty = fill_q == '0;
	assign head       = slot_q[rd_ptr_q];
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule
`default_nettype wire

>>> rtl/pba_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pba_engine: bitmap engine
// Owns the used-page bitmap memory. Allocates by streaming words through a
// read / search / write pipeline, frees by read-modify-write of each word of
// the run, and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module pba_engine (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire  [pba_pkg::CNT_W-1:0]        eff_pages,
	input  pba_pkg::pba_entry_t              q_head,
	input  pba_pkg::pba_q_stat_t             q_stat,
	output logic                             q_pop,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [pba_pkg::OUT_ADDR_W-1:0]   alloc_address,
	output logic [pba_pkg::STATUS_W-1:0]     status
);
	import pba_pkg::*;

	localparam logic [WORD_BITS-1:0] WORD_ONES = '1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ALLOC,
		S_FREE,
		S_RESP
	} state_t;

	// runs of n free pages: bit j set when a run ends at page j
	function automatic logic [WORD_BITS-1:0] run_ends(input logic [WORD_BITS-1:0] fr,
	                                                   input logic [RUN_W-1:0] n);
		logic [WORD_BITS-1:0] g;
		logic [WORD_BITS-1:0] acc;
		logic                 started;
		g       = fr;
		acc     = '1;
		started = 1'b0;
		for (int b = 0; b < RUN_W; b++) begin
			if (n[b]) begin
				acc     = started ? (g & (acc << (1 << b))) : g;
				started = 1'b1;
			end
			g = g & (g << (1 << b));
		end
		return acc;
	endfunction

	function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
		logic [BIT_IDX_W-1:0] pos;
		pos = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (v[j]) begin
				pos = BIT_IDX_W'(j);
			end
		end
		return pos;
	endfunction

	// bitmap memory, valid bits stand in for the all-used reset value
	logic [WORD_BITS-1:0]  mem [NUM_WORDS];
	logic [NUM_WORDS-1:0]  valid_q;

	state_t                state_q;
	logic [WORD_IDX_W:0]   idx_q;
	logic                  more_q;
	logic [RUN_W-1:0]      cnt_q;
	logic [PAGE_W-1:0]     start_q;
	logic [PAGE_W-1:0]     last_q;
	pba_status_t           res_status_q;
	logic [OUT_ADDR_W-1:0] res_addr_q;
	logic                  out_valid_q;
	logic [OUT_ADDR_W-1:0] alloc_address_q;
	pba_status_t           status_q;

	// read stage
	logic                  rd_vld_s1;
	logic [WORD_IDX_W-1:0] rd_idx_s1;
	logic                  rd_wv_s1;
	logic [WORD_BITS-1:0]  rd_data_s1;

	// search stage
	logic                  ev_vld_s2;
	logic                  hit_s2;
	logic [BIT_IDX_W-1:0]  end_s2;
	logic [WORD_IDX_W-1:0] idx_s2;
	logic [WORD_BITS-1:0]  word_s2;

	logic                  issue_alloc;
	logic                  issue_free;
	logic                  rd_en;
	logic [WORD_IDX_W-1:0] rd_addr;
	logic                  alloc_hit;
	logic [WORD_BITS-1:0]  word_s1;
	logic [CNT_W-1:0]      lim;
	logic [WORD_BITS-1:0]  range_mask;
	logic [WORD_BITS-1:0]  ends;
	logic [RUN_W-1:0]      first_sum;
	logic [BIT_IDX_W-1:0]  first_pos;
	logic [WORD_BITS-1:0]  run_mask;
	logic [BIT_IDX_W-1:0]  free_lo;
	logic [BIT_IDX_W-1:0]  free_hi;
	logic [WORD_BITS-1:0]  free_mask;
	logic                  free_last;
	logic                  wr_en;
	logic [WORD_IDX_W-1:0] wr_addr;
	logic [WORD_BITS-1:0]  wr_data;
	logic [CNT_W-1:0]      last_sum;
	logic                  out_load;

	assign q_pop = (state_q == S_IDLE) && !q_stat.empty;

	// word read issue
	assign alloc_hit   = (state_q == S_ALLOC) && ev_vld_s2 && hit_s2;
	assign issue_alloc = (state_q == S_ALLOC) && !idx_q[WORD_IDX_W] && !alloc_hit &&
	                     (CNT_W'({idx_q[WORD_IDX_W-1:0], {BIT_IDX_W{1'b0}}}) < eff_pages);
	assign issue_free  = (state_q == S_FREE) && more_q;
	assign rd_en       = issue_alloc || issue_free;
	assign rd_addr     = idx_q[WORD_IDX_W-1:0];

	// search a word for the first fitting run
	assign word_s1 = rd_wv_s1 ? rd_data_s1 : WORD_ONES;
	assign lim     = eff_pages - CNT_W'({rd_idx_s1, {BIT_IDX_W{1'b0}}});

	always_comb begin
		if (lim >= CNT_W'(WORD_BITS)) begin
			range_mask = WORD_ONES;
		end else begin
			range_mask = WORD_ONES >> (RUN_W'(WORD_BITS) - lim[RUN_W-1:0]);
		end
	end

	assign ends = run_ends(~word_s1 & range_mask, cnt_q);

	// mark the found run
	assign first_sum = {1'b0, end_s2} + 1'b1 - cnt_q;
	assign first_pos = first_sum[BIT_IDX_W-1:0];
	assign run_mask  = (WORD_ONES >> (RUN_W'(WORD_BITS) - cnt_q)) << first_pos;

	// bits of this word that the free clears
	assign free_last = rd_idx_s1 == last_q[PAGE_W-1:BIT_IDX_W];
	assign free_lo   = (rd_idx_s1 == start_q[PAGE_W-1:BIT_IDX_W]) ? start_q[BIT_IDX_W-1:0]
	                                                              : '0;
	assign free_hi   = free_last ? last_q[BIT_IDX_W-1:0] : BIT_IDX_W'(WORD_BITS - 1);
	assign free_mask = (WORD_ONES << free_lo) &
	                   (WORD_ONES >> (BIT_IDX_W'(WORD_BITS - 1) - free_hi));

	// single write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s2;
		wr_data = word_s2 | run_mask;
		if (alloc_hit) begin
			wr_en = 1'b1;
		end else if ((state_q == S_FREE) && rd_vld_s1) begin
			wr_en   = 1'b1;
			wr_addr = rd_idx_s1;
			wr_data = word_s1 & ~free_mask;
		end
	end

	assign last_sum = CNT_W'(q_head.start) + q_head.count - 1'b1;
	assign out_load = !out_valid_q || !out_stall;

	// memory and datapath registers
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_idx_s1 <= rd_addr;
		rd_wv_s1  <= valid_q[rd_addr];
		hit_s2    <= |ends;
		end_s2    <= lowest_set(ends);
		idx_s2    <= rd_idx_s1;
		word_s2   <= word_s1;
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			idx_q           <= '0;
			more_q          <= 1'b0;
			cnt_q           <= '0;
			start_q         <= '0;
			last_q          <= '0;
			res_status_q    <= ST_DONE;
			res_addr_q      <= '0;
			rd_vld_s1       <= 1'b0;
			ev_vld_s2       <= 1'b0;
			valid_q         <= '0;
			out_valid_q     <= 1'b0;
			alloc_address_q <= '0;
			status_q        <= ST_DONE;
		end else begin
			rd_vld_s1 <= rd_en;
			ev_vld_s2 <= (state_q == S_ALLOC) && rd_vld_s1 && !alloc_hit;
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			// result beat leaves; in S_RESP the load below decides
			if (out_valid_q && !out_stall && (state_q != S_RESP)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_stat.empty) begin
						cnt_q        <= q_head.count[RUN_W-1:0];
						start_q      <= q_head.start;
						last_q       <= last_sum[PAGE_W-1:0];
						res_status_q <= q_head.status;
						res_addr_q   <= '0;
						case (q_head.op)
							OP_ALLOC: begin
								idx_q   <= '0;
								state_q <= S_ALLOC;
							end
							OP_FREE: begin
								idx_q   <= {1'b0, q_head.start[PAGE_W-1:BIT_IDX_W]};
								more_q  <= 1'b1;
								state_q <= S_FREE;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_ALLOC: begin
					if (issue_alloc) begin
						idx_q <= idx_q + 1'b1;
					end
					if (alloc_hit) begin
						res_status_q <= ST_DONE;
						res_addr_q   <= OUT_ADDR_W'({idx_s2, first_pos, {PAGE_SHIFT{1'b0}}});
						state_q      <= S_RESP;
					end else if (!issue_alloc && !rd_vld_s1 && !ev_vld_s2) begin
						res_status_q <= ST_NO_RUN;
						res_addr_q   <= '0;
						state_q      <= S_RESP;
					end
				end
				S_FREE: begin
					if (issue_free) begin
						if (idx_q[WORD_IDX_W-1:0] == last_q[PAGE_W-1:BIT_IDX_W]) begin
							more_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					if (rd_vld_s1 && free_last) begin
						res_status_q <= ST_DONE;
						state_q      <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_load) begin
						out_valid_q     <= 1'b1;
						alloc_address_q <= res_addr_q;
						status_q        <= res_status_q;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign alloc_address = alloc_address_q;
	assign status        = status_q;

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for page_bitmap_allocator_core
// A queue of requests feeds a bursty driver. Every accepted beat runs through
// a local copy of the page bitmap, which gives the expected address and
// status. The monitor stalls on a changing pattern and checks each result
// beat in order. total_pages is rewritten between phases while the core idles.
// ----------------------------------------------------------------------------
module tb;
	import pba_pkg::*;

	typedef struct {
		logic              cmd;
		logic [CNT_W-1:0]  cnt;
		logic [ADDR_W-1:0] addr;
	} page_req_t;

	typedef struct {
		logic [OUT_ADDR_W-1:0] addr;
		pba_status_t           st;
	} page_result_t;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	// core ports
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic [CNT_W-1:0]      total_pages = 13'd4096;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic                  command     = CMD_ALLOC;
	logic [CNT_W-1:0]      page_count  = '0;
	logic [ADDR_W-1:0]     address     = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [OUT_ADDR_W-1:0] alloc_address;
	logic [STATUS_W-1:0]   status;

	page_bitmap_allocator_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.total_pages   (total_pages),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.page_count    (page_count),
		.address       (address),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.alloc_address (alloc_address),
		.status        (status)
	);

	// local bitmap and register copy
	logic [WORD_BITS-1:0] used_map [NUM_WORDS];
	logic [CNT_W-1:0]     cfg_pages = 13'd4096;

	page_req_t    pending_reqs[$];
	page_result_t expected_results[$];
	int           queued_reqs   = 0;
	int           accepted_reqs = 0;
	int           fail_count    = 0;

	// Apply one request to the local bitmap, return the result it should give.
	function automatic page_result_t apply_request(logic cmd, logic [CNT_W-1:0] cnt,
			logic [ADDR_W-1:0] addr);
		page_result_t r;
		longint pages, words, base, run, first, start, a, n;
		bit found;
		n = {51'b0, cnt};
		pages = (cfg_pages > MAX_PAGES) ? MAX_PAGES : {51'b0, cfg_pages};
		r.addr = '0;
		r.st = ST_DONE;
		if (cmd == CMD_ALLOC) begin
			if (n == 0) begin
				r.st = ST_ZERO;
			end else begin
				// first fit, a run never spans two words
				r.st = ST_NO_RUN;
				words = (pages + WORD_BITS - 1) / WORD_BITS;
				found = 1'b0;
				for (longint i = 0; i < words && !found; i++) begin
					if (&used_map[i])
						continue;
					base = i * WORD_BITS;
					run = 0;
					for (longint j = 0; j < WORD_BITS && base + j < pages && !found; j++) begin
						if (used_map[i][j]) begin
							run = 0;
						end else begin
							run++;
							if (run == n) begin
								first = base + j + 1 - n;
								for (longint k = first; k < first + n; k++)
									used_map[k / WORD_BITS][k % WORD_BITS] = 1'b1;
								r.addr = OUT_ADDR_W'(first * PAGE_BYTES);
								r.st = ST_DONE;
								found = 1'b1;
							end
						end
					end
				end
			end
		end else begin
			// alignment is checked ahead of range
			a = {32'b0, addr};
			if (a % PAGE_BYTES != 0) begin
				r.st = ST_MISALIGNED;
			end else begin
				start = a / PAGE_BYTES;
				if (start + n > pages) begin
					r.st = ST_RANGE;
				end else begin
					for (longint k = start; k < start + n; k++)
						used_map[(k / WORD_BITS) % NUM_WORDS][k % WORD_BITS] = 1'b0;
				end
			end
		end
		return r;
	endfunction

	// request driver: bursts with random gaps
	page_req_t next_req;
	int        burst_left = 0;
	int        gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			command    <= CMD_ALLOC;
			page_count <= '0;
			address    <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(apply_request(command, page_count, address));
				accepted_reqs++;
			end
			// payload holds while stalled
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					next_req = pending_reqs.pop_front();
					in_valid   <= 1'b1;
					command    <= next_req.cmd;
					page_count <= next_req.cnt;
					address    <= next_req.addr;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and stall pattern
	page_result_t want;
	stall_mode_t  stall_mode  = STALL_NONE;
	logic [31:0]  cycle_count = '0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected: alloc_address %h status %0d",
						alloc_address, status);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (alloc_address !== want.addr) begin
						$error("alloc_address: expected %h, got %h", want.addr, alloc_address);
						fail_count++;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						fail_count++;
					end
				end
			end
			cycle_count <= cycle_count + 1;
			if (cycle_count[6:0] == 7'd0)
				stall_mode = stall_mode_t'($urandom_range(0, 3));
			case (stall_mode)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:     out_stall <= (cycle_count[3:0] < 4'd6);
			endcase
		end
	end

	task automatic push_request(logic cmd, logic [CNT_W-1:0] cnt, logic [ADDR_W-1:0] addr);
		page_req_t q;
		q.cmd = cmd;
		q.cnt = cnt;
		q.addr = addr;
		pending_reqs.push_back(q);
		queued_reqs++;
	endtask

	// wait until every request is in and answered
	task automatic wait_drained();
		do @(negedge clk); while (accepted_reqs != queued_reqs || expected_results.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_total_pages(logic [CNT_W-1:0] v);
		@(posedge clk);
		cfg_valid   <= 1'b1;
		total_pages <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_pages = v;
	endtask

	// stimulus
	initial begin : stimulus
		int phase_pages [8];
		int phase_items [8];
		int pages_now, pick, start, span, top, lo;
		logic [ADDR_W-1:0] addr;
		phase_pages = '{4096, 100, 8191, 0, 1, 65, 4095, 0};
		phase_items = '{300, 200, 250, 40, 40, 150, 250, 200};
		phase_pages[7] = $urandom_range(0, 8191);
		foreach (used_map[w])
			used_map[w] = '1;

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		write_total_pages(13'd4096);

		// directed: everything used at reset
		push_request(CMD_ALLOC, 13'd1, 32'h0);
		push_request(CMD_ALLOC, 13'd0, 32'h0);
		push_request(CMD_FREE,  13'd64, 32'h0);
		// page zero comes back with address 0
		push_request(CMD_ALLOC, 13'd1, 32'h0);
		push_request(CMD_ALLOC, 13'd63, 32'h0);
		push_request(CMD_FREE,  13'd0, 32'h0000_1000);
		push_request(CMD_FREE,  13'd1, 32'h0000_0001);
		// misaligned wins over out of range
		push_request(CMD_FREE,  13'd8191, 32'hFFFF_FFFF);
		push_request(CMD_FREE,  13'd1, 32'hFFFF_F000);
		push_request(CMD_FREE,  13'd8191, 32'h0);
		// run ending exactly at the top is fine, one past is not
		push_request(CMD_FREE,  13'd0, 32'(4096 * PAGE_BYTES));
		push_request(CMD_FREE,  13'd1, 32'(4096 * PAGE_BYTES));
		push_request(CMD_FREE,  13'd64, 32'(4032 * PAGE_BYTES));
		push_request(CMD_FREE,  13'd64, 32'(4032 * PAGE_BYTES));
		push_request(CMD_ALLOC, 13'd64, 32'hFFFF_FFFF);
		// counts above a word never fit
		push_request(CMD_ALLOC, 13'd65, 32'h0);
		push_request(CMD_ALLOC, 13'd8191, 32'hFFFF_FFFF);
		push_request(CMD_FREE,  13'd4096, 32'h0);
		push_request(CMD_ALLOC, 13'd64, 32'h0);
		push_request(CMD_ALLOC, 13'd8, 32'h0);
		push_request(CMD_FREE,  13'd2, 32'(65 * PAGE_BYTES));
		push_request(CMD_ALLOC, 13'd3, 32'h0);
		push_request(CMD_ALLOC, 13'd2, 32'h0);
		push_request(CMD_FREE,  13'd4096, 32'h0);
		wait_drained();

		// random phases, one register setting each
		for (int p = 0; p < 8; p++) begin
			write_total_pages(CNT_W'(phase_pages[p]));
			pages_now = (phase_pages[p] > MAX_PAGES) ? MAX_PAGES : phase_pages[p];
			if ($urandom_range(0, 1) == 0)
				push_request(CMD_FREE, CNT_W'(pages_now), 32'h0);
			for (int n = 0; n < phase_items[p]; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					// typical allocate, mostly small
					push_request(CMD_ALLOC, CNT_W'(($urandom_range(0, 3) == 0) ?
						$urandom_range(1, 64) : $urandom_range(1, 8)), $urandom);
				end else if (pick < 80) begin
					// well-formed free inside the tracked range
					if (pages_now > 0) begin
						start = $urandom_range(0, pages_now - 1);
						span = pages_now - start;
						top = ($urandom_range(0, 4) == 0) ? 64 : 12;
						if (span < top)
							top = span;
						push_request(CMD_FREE, CNT_W'($urandom_range(1, top)),
							32'(start * PAGE_BYTES));
					end else begin
						push_request(CMD_FREE, 13'd0, 32'h0);
					end
				end else if (pick < 85) begin
					push_request(CMD_ALLOC, CNT_W'($urandom_range(0, 8191)), $urandom);
				end else if (pick < 90) begin
					addr = $urandom;
					if (addr[PAGE_SHIFT-1:0] == '0)
						addr[0] = 1'b1;
					push_request(CMD_FREE, CNT_W'($urandom_range(0, 8191)), addr);
				end else if (pick < 95) begin
					// around the top of the range
					lo = (pages_now > 8) ? pages_now - 8 : 0;
					start = $urandom_range(lo, pages_now + 8);
					push_request(CMD_FREE, CNT_W'($urandom_range(0, 80)),
						32'(start * PAGE_BYTES));
				end else if (pick < 97) begin
					push_request(CMD_FREE, CNT_W'(pages_now), 32'h0);
				end else begin
					push_request(1'($urandom_range(0, 1)), CNT_W'($urandom_range(0, 8191)),
						$urandom);
				end
			end
			wait_drained();
		end

		if (fail_count == 0)
			$display("page_bitmap_allocator_core test passed");
		else
			$display("page_bitmap_allocator_core test failed");
		$finish;
	end

	// watchdog
	initial begin
		#20000000;
		$display("page_bitmap_allocator_core test failed");
		$finish;
	end

endmodule
